>>> src/ogru_pkg.sv
// Shared types, constants and the occupancy percent table of the ray-update grid.
`default_nettype none
package ogru_pkg;
    localparam int GRID_WIDTH_DEF  = 150;
    localparam int GRID_HEIGHT_DEF = 100;

    localparam logic [1:0] REQ_HIT  = 2'd0;
    localparam logic [1:0] REQ_CAR  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic [2:0] CFG_ROBOT_X  = 3'd0;
    localparam logic [2:0] CFG_ROBOT_Y  = 3'd1;
    localparam logic [2:0] CFG_OCC_STEP = 3'd2;
    localparam logic [2:0] CFG_FREE_STEP = 3'd3;
    localparam logic [2:0] CFG_ROW_START = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_HIT_RD, ST_HIT_WAIT, ST_HIT_WR, ST_RAY_RD,
        ST_RAY_WAIT, ST_RAY_WR, ST_READ_RD, ST_READ_WAIT, ST_READ_WR, ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;   // write zero at clear address, advance it
        logic load;         // capture the input item and set up the ray
        logic wr_hit;       // write the updated target cell
        logic ray_rd;       // read the current ray cell
        logic ray_wr;       // write the current ray cell (if eligible)
        logic ray_adv;      // step the ray walk
        logic rd_clr;       // write zero at the read cell
        logic out_load;     // latch the result
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic in_window;    // hit/car within window
        logic hit_lin_ok;   // target linear index in range
        logic read_ok;      // read cell inside grid
        logic ray_last;     // current ray point is the last one
        logic [1:0] req;
    } stat_t;

    function automatic logic signed [7:0] percent_of(input logic signed [15:0] l);
        logic signed [7:0] p;
        if (l == 16'sd0) p = -8'sd1;
        else if (l >= 16'sd38) p = 8'sd100;
        else if (l >= 16'sd6) p = 8'sd99;
        else if (l <= -16'sd5) p = 8'sd0;
        else begin
            case (l[3:0])
                4'hC: p = 8'sd1;
                4'hD: p = 8'sd4;
                4'hE: p = 8'sd11;
                4'hF: p = 8'sd26;
                4'h1: p = 8'sd73;
                4'h2: p = 8'sd88;
                4'h3: p = 8'sd95;
                4'h4: p = 8'sd98;
                default: p = 8'sd99;
            endcase
        end
        return p;
    endfunction
endpackage
`default_nettype wire

>>> src/ogru_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module ogru_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 15000
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] addr,
    input  wire  [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> src/ogru_ctrl.sv
// Controller state machine of the ray-update grid.
`default_nettype none
module ogru_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire                 m_ready,
    input  ogru_pkg::stat_t     stat,
    output ogru_pkg::cmd_t      cmd
);
    ogru_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ogru_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ogru_pkg::ST_CLEAR: if (stat.clear_done) state_next = ogru_pkg::ST_IDLE;
            ogru_pkg::ST_IDLE: if (s_valid) begin
                if (stat.req == ogru_pkg::REQ_HIT || stat.req == ogru_pkg::REQ_CAR)
                    state_next = ogru_pkg::ST_HIT_RD;
                else if (stat.req == ogru_pkg::REQ_READ)
                    state_next = ogru_pkg::ST_READ_RD;
                else
                    state_next = ogru_pkg::ST_DONE;
            end
            ogru_pkg::ST_HIT_RD:
                state_next = stat.in_window ? ogru_pkg::ST_HIT_WAIT : ogru_pkg::ST_DONE;
            ogru_pkg::ST_HIT_WAIT: state_next = ogru_pkg::ST_HIT_WR;
            ogru_pkg::ST_HIT_WR:   state_next = ogru_pkg::ST_RAY_RD;
            ogru_pkg::ST_RAY_RD:   state_next = ogru_pkg::ST_RAY_WAIT;
            ogru_pkg::ST_RAY_WAIT: state_next = ogru_pkg::ST_RAY_WR;
            ogru_pkg::ST_RAY_WR:
                state_next = stat.ray_last ? ogru_pkg::ST_DONE : ogru_pkg::ST_RAY_RD;
            ogru_pkg::ST_READ_RD:
                state_next = stat.read_ok ? ogru_pkg::ST_READ_WAIT : ogru_pkg::ST_DONE;
            ogru_pkg::ST_READ_WAIT: state_next = ogru_pkg::ST_READ_WR;
            ogru_pkg::ST_READ_WR:   state_next = ogru_pkg::ST_DONE;
            ogru_pkg::ST_DONE: if (m_ready) state_next = ogru_pkg::ST_IDLE;
            default: state_next = ogru_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ogru_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
            ogru_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                // An unused request code finishes at once with an all-zero result.
                cmd.out_load = s_valid && stat.req != ogru_pkg::REQ_HIT
                               && stat.req != ogru_pkg::REQ_CAR
                               && stat.req != ogru_pkg::REQ_READ;
            end
            ogru_pkg::ST_HIT_RD: cmd.out_load = !stat.in_window;
            ogru_pkg::ST_HIT_WAIT: ;
            ogru_pkg::ST_HIT_WR:   cmd.wr_hit = 1'b1;
            ogru_pkg::ST_RAY_RD, ogru_pkg::ST_RAY_WAIT: cmd.ray_rd = 1'b1;
            ogru_pkg::ST_RAY_WR: begin
                cmd.ray_wr   = 1'b1;
                cmd.ray_adv  = 1'b1;
                cmd.out_load = stat.ray_last;
            end
            ogru_pkg::ST_READ_RD: cmd.out_load = !stat.read_ok;
            ogru_pkg::ST_READ_WAIT: ;
            ogru_pkg::ST_READ_WR: begin
                cmd.rd_clr   = 1'b1;
                cmd.out_load = 1'b1;
            end
            ogru_pkg::ST_DONE: m_valid = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> src/ogru_dp.sv
// Datapath of the ray-update grid: registers, ray walker and the log-odds store.
`default_nettype none
module ogru_dp #(
    parameter int GRID_WIDTH  = ogru_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogru_pkg::GRID_HEIGHT_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  ogru_pkg::cmd_t          cmd,
    output ogru_pkg::stat_t         stat,
    input  wire                     cfg_we,
    input  wire  [2:0]              cfg_index,
    input  wire  [9:0]              cfg_data,
    input  wire  [1:0]              s_req_type,
    input  wire  signed [9:0]       s_cell_x,
    input  wire  signed [9:0]       s_cell_y,
    output logic                    m_accepted,
    output logic [10:0]             m_cells_written,
    output logic signed [15:0]      m_log_odds,
    output logic signed [7:0]       m_occupancy_percent
);
    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW = $clog2(CELLS);
    localparam logic signed [21:0] W22 = 22'(GRID_WIDTH);
    localparam logic signed [21:0] C22 = 22'(CELLS);
    localparam logic signed [11:0] W12 = 12'(GRID_WIDTH);
    localparam logic signed [11:0] H12 = 12'(GRID_HEIGHT);

    logic signed [9:0] rx_reg, ry_reg, row_reg;
    logic [6:0]        occ_reg;
    logic signed [7:0] free_reg;
    logic [1:0]        req_reg;
    logic signed [9:0] hx_reg, hy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_reg <= '0; ry_reg <= '0; occ_reg <= 7'd4;
            free_reg <= -8'sd1; row_reg <= -10'sd10;
        end else if (cfg_we) begin
            case (cfg_index)
                ogru_pkg::CFG_ROBOT_X:   rx_reg <= cfg_data;
                ogru_pkg::CFG_ROBOT_Y:   ry_reg <= cfg_data;
                ogru_pkg::CFG_OCC_STEP:  occ_reg <= cfg_data[6:0];
                ogru_pkg::CFG_FREE_STEP: free_reg <= cfg_data[7:0];
                ogru_pkg::CFG_ROW_START: row_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Ray walker state: walk along the major axis, minor axis stepped by error.
    logic signed [11:0] maj_reg, min_reg, maj_end_reg, dmaj_reg, dmin_reg;
    logic signed [12:0] err_reg;
    logic               steep_reg, ystep_neg_reg;

    logic signed [11:0] adx, ady, x0, y0, x1, y1, a0, b0, a1, b1;
    logic               steep;
    always_comb begin
        x0 = 12'(rx_reg); y0 = 12'(ry_reg);
        x1 = 12'(s_cell_x); y1 = 12'(s_cell_y);
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        steep = ady > adx;
        a0 = steep ? y0 : x0; b0 = steep ? x0 : y0;
        a1 = steep ? y1 : x1; b1 = steep ? x1 : y1;
        if (a0 > a1) begin
            {a0, a1} = {a1, a0};
            {b0, b1} = {b1, b0};
        end
    end

    logic [AW-1:0] clr_addr_reg;
    logic [10:0]   cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_step && clr_addr_reg != AW'(CELLS - 1)) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end
    assign stat.clear_done = (clr_addr_reg == AW'(CELLS - 1));

    // Current ray point and its linear index.
    logic signed [11:0] px, py;
    logic signed [21:0] ray_lin, hit_lin;
    logic signed [12:0] err_add, err_new;
    logic               ray_ok, ray_is_hit;
    always_comb begin
        px = steep_reg ? min_reg : maj_reg;
        py = steep_reg ? maj_reg : min_reg;
        ray_lin = 22'(py) * W22 + 22'(px);
        ray_ok = ray_lin >= 0 && ray_lin < C22;
        ray_is_hit = px == 12'(hx_reg) && py == 12'(hy_reg);
        hit_lin = 22'(hy_reg) * W22 + 22'(hx_reg);
        err_add = err_reg + 13'(dmin_reg);
    end

    logic signed [11:0] dyw;
    always_comb begin
        dyw = 12'(hy_reg) - 12'(row_reg);
        stat.in_window = hx_reg >= 0 && 12'(hx_reg) < W12 && dyw >= 0 && dyw < H12;
        stat.hit_lin_ok = hit_lin >= 0 && hit_lin < C22;
        stat.read_ok = hx_reg >= 0 && 12'(hx_reg) < W12 && hy_reg >= 0 && 12'(hy_reg) < H12;
        stat.ray_last = maj_reg == maj_end_reg;
        stat.req = s_req_type;
    end
    assign err_new = err_add;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_req_type;
            hx_reg <= s_cell_x; hy_reg <= s_cell_y;
            steep_reg <= steep;
            maj_reg <= a0; maj_end_reg <= a1; min_reg <= b0;
            dmaj_reg <= a1 - a0;
            dmin_reg <= (b1 > b0) ? b1 - b0 : b0 - b1;
            ystep_neg_reg <= !(b0 < b1);
            err_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cmd.wr_hit && stat.hit_lin_ok) cnt_reg <= cnt_reg + 1'b1;
            if (cmd.ray_wr && ray_ok && !ray_is_hit) cnt_reg <= cnt_reg + 1'b1;
            if (cmd.ray_adv) begin
                maj_reg <= maj_reg + 1'b1;
                // The error can go negative, so the compare is signed.
                if ($signed({err_new, 1'b0}) >= 14'(dmaj_reg)) begin
                    min_reg <= ystep_neg_reg ? min_reg - 1'b1 : min_reg + 1'b1;
                    err_reg <= err_new - 13'(dmaj_reg);
                end else begin
                    err_reg <= err_new;
                end
            end
        end
    end

    // Store access.
    logic [AW-1:0]     addr;
    logic              we;
    logic [15:0]       wdata, rdata;
    logic signed [16:0] sum;
    always_comb begin
        addr = AW'(hit_lin);
        we = 1'b0;
        wdata = '0;
        sum = 17'(signed'(rdata)) + ((cmd.wr_hit) ? 17'(occ_reg) : 17'(free_reg));
        if (cmd.clear_step) begin
            addr = clr_addr_reg; we = 1'b1;
        end else if (cmd.ray_rd || cmd.ray_wr) begin
            addr = AW'(ray_lin);
            we = cmd.ray_wr && ray_ok && !ray_is_hit;
        end else begin
            we = (cmd.wr_hit && stat.hit_lin_ok) || cmd.rd_clr;
        end
        if (cmd.wr_hit && req_reg == ogru_pkg::REQ_CAR) wdata = 16'h7FFF;
        else if (cmd.rd_clr || cmd.clear_step) wdata = '0;
        else if (sum > 17'sd32767) wdata = 16'h7FFF;
        else if (sum < -17'sd32768) wdata = 16'h8000;
        else wdata = sum[15:0];
    end

    ogru_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_accepted <= 1'b0;
            m_cells_written <= '0;
            m_log_odds <= '0;
            m_occupancy_percent <= '0;
            if (req_reg == ogru_pkg::REQ_READ && !cmd.load) begin
                m_occupancy_percent <= -8'sd1;
                if (cmd.rd_clr) begin
                    m_accepted <= 1'b1;
                    m_cells_written <= 11'd1;
                    m_log_odds <= rdata;
                    m_occupancy_percent <= ogru_pkg::percent_of(rdata);
                end
            end else if (cmd.ray_wr) begin
                m_accepted <= 1'b1;
                m_cells_written <= cnt_reg + 11'(ray_ok && !ray_is_hit);
            end
        end
    end
endmodule
`default_nettype wire

>>> src/occupancy_grid_ray_update.sv
// Top level of the log-odds occupancy grid with ray update and read-and-clear.
// After reset the block clears all GRID_WIDTH*GRID_HEIGHT cells of its store
// (15000 by default) before it takes the first item. A hit or car item reads
// and writes its target cell, then walks the ray, whose length is the
// major-axis distance from robot to hit plus one: each ray cell costs a read,
// a read wait and a write on the single store port. A read item reads and
// clears its cell; a rejected hit or car and an unused request code skip the
// store. Each item ends with the output handshake. One item is in work at a time.
`default_nettype none
module occupancy_grid_ray_update #(
    parameter int GRID_WIDTH  = ogru_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ogru_pkg::GRID_HEIGHT_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_we,
    input  wire  [2:0]         cfg_index,
    input  wire  [9:0]         cfg_data,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [1:0]         s_req_type,
    input  wire  signed [9:0]  s_cell_x,
    input  wire  signed [9:0]  s_cell_y,
    output logic               m_valid,
    input  wire                m_ready,
    output logic               m_accepted,
    output logic [10:0]        m_cells_written,
    output logic signed [15:0] m_log_odds,
    output logic signed [7:0]  m_occupancy_percent
);
    ogru_pkg::cmd_t  cmd;
    ogru_pkg::stat_t stat;

    ogru_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    ogru_dp #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_req_type(s_req_type), .s_cell_x(s_cell_x), .s_cell_y(s_cell_y),
        .m_accepted(m_accepted), .m_cells_written(m_cells_written),
        .m_log_odds(m_log_odds), .m_occupancy_percent(m_occupancy_percent)
    );
endmodule
`default_nettype wire
